// ===== design/mack_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mack_pkg: shared types and constants of the message ack/retry controller
// Item codes, event codes, register indexes, reset values and the item and
// result records passed between the control stage and the top level.
// ----------------------------------------------------------------------------
package mack_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int TIME_W      = 24;
    localparam int TALLY_W     = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 24;

    // Number of transmissions per message
    localparam logic [1:0] RETRY_LIMIT = 2'd2;
    localparam logic [1:0] FIRST_TRY   = 2'd1;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_START_DELAY = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACK_TIMEOUT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HB_EVERY    = 2'd2;

    // Register reset values
    localparam logic [TIME_W-1:0]  START_DELAY_RST = 24'd240000;
    localparam logic [TIME_W-1:0]  ACK_TIMEOUT_RST = 24'd180000;
    localparam logic [TALLY_W-1:0] HB_EVERY_RST    = 8'd5;

    // Kind of an input item
    typedef enum logic [2:0] {
        FUNC_TICK    = 3'd0,
        FUNC_PEER    = 3'd1,
        FUNC_ACK     = 3'd2,
        FUNC_ENQUEUE = 3'd3,
        FUNC_PUBLISH = 3'd4,
        FUNC_FAULT   = 3'd5
    } func_t;

    // Delivery event of a result item
    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_SENT         = 3'd1,
        EV_RESENT       = 3'd2,
        EV_CONFIRMED    = 3'd3,
        EV_ABANDON_TWO  = 3'd4,
        EV_ABANDON_PEER = 3'd5,
        EV_QUEUED       = 3'd6,
        EV_REJECTED     = 3'd7
    } event_t;

    typedef struct packed {
        func_t           func;
        logic            peer_available;
        logic [ID_W-1:0] message_id;
        logic            link_up;
    } item_t;

    typedef struct packed {
        logic            send_heartbeat;
        logic            send_fault_notice;
        logic            send_message;
        logic [ID_W-1:0] out_message_id;
        event_t          event_res;
        logic            accepted;
        logic            peer_ready;
        logic [2:0]      queue_count;
        logic            running;
    } result_t;

endpackage

// ===== design/mack_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mack_ram: simple dual-port synchronous RAM
// One write port, one read port with registered data (read-first).
// ----------------------------------------------------------------------------
module mack_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mack_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mack_ctrl: delivery control stage
// Holds the configuration and control state, decodes one item per cycle
// while item_fire is high, keeps the message queue in RAM, forms the result.
// ----------------------------------------------------------------------------
module mack_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mack_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mack_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              item_fire,
    input  mack_pkg::item_t                   item,
    output mack_pkg::result_t                 result
);
    import mack_pkg::*;

    // Configuration
    logic [TIME_W-1:0]  start_delay_reg;
    logic [TIME_W-1:0]  ack_timeout_reg;
    logic [TALLY_W-1:0] hb_every_reg;

    // Control state
    logic               running_reg,   running_next;
    logic [TIME_W-1:0]  elapsed_reg,   elapsed_next;
    logic               peer_reg,      peer_next;
    logic [PTR_W-1:0]   head_reg,      head_next;
    logic [FILL_W-1:0]  fill_reg,      fill_next;
    logic               waiting_reg,   waiting_next;
    logic [1:0]         attempt_reg,   attempt_next;
    logic [TIME_W-1:0]  since_reg,     since_next;
    logic               ack_seen_reg,  ack_seen_next;
    logic [TALLY_W-1:0] tally_reg,     tally_next;
    logic               hb_due_reg,    hb_due_next;

    // Queue RAM access
    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    logic [ID_W-1:0]    mem_rdata;
    logic               fwd_reg,       fwd_next;
    logic [ID_W-1:0]    fwd_data_reg;
    logic [ID_W-1:0]    head_id;
    logic [PTR_W-1:0]   tail_ptr;
    logic [FILL_W:0]    tail_sum;
    logic [PTR_W-1:0]   head_inc;
    logic [TIME_W-1:0]  elapsed_inc;
    logic [TIME_W-1:0]  since_inc;
    logic [TALLY_W-1:0] tally_inc;

    mack_ram #(
        .DATA_W (ID_W),
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (item.message_id),
        .raddr (head_next),
        .rdata (mem_rdata)
    );

    // Head entry: take the forwarded write when it hit the address just read
    assign head_id = fwd_reg ? fwd_data_reg : mem_rdata;

    // Tail slot and wrapped head increment
    always_comb begin
        tail_sum = (FILL_W + 1)'(head_reg) + (FILL_W + 1)'(fill_reg);
        if (tail_sum >= (FILL_W + 1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (FILL_W + 1)'(QUEUE_DEPTH);
        end
        tail_ptr = tail_sum[PTR_W-1:0];
        head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    end

    // Saturating counters
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign since_inc   = (since_reg == '1)   ? since_reg   : since_reg + 1'b1;
    assign tally_inc   = (tally_reg == '1)   ? tally_reg   : tally_reg + 1'b1;

    // Decode the item and compute next state and result
    always_comb begin
        running_next  = running_reg;
        elapsed_next  = elapsed_reg;
        peer_next     = peer_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        waiting_next  = waiting_reg;
        attempt_next  = attempt_reg;
        since_next    = since_reg;
        ack_seen_next = ack_seen_reg;
        tally_next    = tally_reg;
        hb_due_next   = hb_due_reg;
        mem_we        = 1'b0;
        mem_waddr     = tail_ptr;
        result        = '0;
        result.event_res = EV_NONE;

        if (item_fire) begin
            case (item.func)
                FUNC_TICK: begin
                    if (!running_reg) begin
                        // Start-up delay
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= start_delay_reg) begin
                            running_next = 1'b1;
                        end
                    end else begin
                        if (hb_due_reg) begin
                            hb_due_next           = 1'b0;
                            result.send_heartbeat = item.link_up;
                        end
                        if (!waiting_reg) begin
                            // Launch the head message
                            if (fill_reg != '0 && peer_reg) begin
                                attempt_next          = FIRST_TRY;
                                ack_seen_next         = 1'b0;
                                since_next            = '0;
                                waiting_next          = 1'b1;
                                result.send_message   = 1'b1;
                                result.out_message_id = head_id;
                                result.event_res      = EV_SENT;
                            end
                        end else if (ack_seen_reg) begin
                            // Confirm and drop the head
                            result.out_message_id = head_id;
                            result.event_res      = EV_CONFIRMED;
                            if (fill_reg != '0) begin
                                head_next = head_inc;
                                fill_next = fill_reg - 1'b1;
                            end
                            waiting_next  = 1'b0;
                            ack_seen_next = 1'b0;
                        end else begin
                            // Ack timer
                            since_next = since_inc;
                            if (since_inc >= ack_timeout_reg) begin
                                result.out_message_id = head_id;
                                if (attempt_reg < RETRY_LIMIT && peer_reg) begin
                                    attempt_next        = RETRY_LIMIT;
                                    ack_seen_next       = 1'b0;
                                    since_next          = '0;
                                    result.send_message = 1'b1;
                                    result.event_res    = EV_RESENT;
                                end else begin
                                    result.event_res = (attempt_reg >= RETRY_LIMIT) ?
                                                       EV_ABANDON_TWO : EV_ABANDON_PEER;
                                    if (fill_reg != '0) begin
                                        head_next = head_inc;
                                        fill_next = fill_reg - 1'b1;
                                    end
                                    waiting_next = 1'b0;
                                end
                            end
                        end
                    end
                end
                FUNC_PEER: begin
                    if (running_reg) begin
                        peer_next = item.peer_available;
                    end
                end
                FUNC_ACK: begin
                    if (running_reg && waiting_reg) begin
                        ack_seen_next = 1'b1;
                    end
                end
                FUNC_ENQUEUE: begin
                    result.out_message_id = item.message_id;
                    if (fill_reg >= FILL_W'(QUEUE_DEPTH)) begin
                        result.event_res = EV_REJECTED;
                    end else begin
                        mem_we           = 1'b1;
                        fill_next        = fill_reg + 1'b1;
                        result.event_res = EV_QUEUED;
                        result.accepted  = 1'b1;
                    end
                end
                FUNC_PUBLISH: begin
                    if (running_reg) begin
                        if (tally_inc >= hb_every_reg) begin
                            hb_due_next = 1'b1;
                            tally_next  = '0;
                        end else begin
                            tally_next = tally_inc;
                        end
                    end
                end
                FUNC_FAULT: begin
                    result.send_fault_notice = running_reg & item.link_up;
                end
                default: begin
                end
            endcase
        end

        // Status after the item
        result.peer_ready  = peer_next;
        result.queue_count = 3'(fill_next);
        result.running     = running_next;

        // Forward a write that lands on the entry being read
        fwd_next = mem_we && (mem_waddr == head_next);
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_delay_reg <= START_DELAY_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            hb_every_reg    <= HB_EVERY_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_START_DELAY: start_delay_reg <= cfg_wdata[TIME_W-1:0];
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_wdata[TIME_W-1:0];
                CFG_HB_EVERY:    hb_every_reg    <= cfg_wdata[TALLY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= 1'b0;
            elapsed_reg  <= '0;
            peer_reg     <= 1'b0;
            head_reg     <= '0;
            fill_reg     <= '0;
            waiting_reg  <= 1'b0;
            attempt_reg  <= '0;
            since_reg    <= '0;
            ack_seen_reg <= 1'b0;
            tally_reg    <= '0;
            hb_due_reg   <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            running_reg  <= running_next;
            elapsed_reg  <= elapsed_next;
            peer_reg     <= peer_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            waiting_reg  <= waiting_next;
            attempt_reg  <= attempt_next;
            since_reg    <= since_next;
            ack_seen_reg <= ack_seen_next;
            tally_reg    <= tally_next;
            hb_due_reg   <= hb_due_next;
            fwd_reg      <= fwd_next;
        end
    end

    // Forwarded data
    always_ff @(posedge aclk) begin
        fwd_data_reg <= item.message_id;
    end

    // A message in flight always sits at the queue head
    assert property (@(posedge aclk) disable iff (!aresetn)
        waiting_reg |-> (fill_reg != '0))
        else $error("waiting for ack with an empty queue");

    // An ack is only latched for a message in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        ack_seen_reg |-> waiting_reg)
        else $error("ack recorded while idle");

    // In flight means first or second try
    assert property (@(posedge aclk) disable iff (!aresetn)
        waiting_reg |-> (attempt_reg == FIRST_TRY || attempt_reg == RETRY_LIMIT))
        else $error("bad attempt number");

    // Queue writes only go to free slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (fill_reg < FILL_W'(QUEUE_DEPTH)))
        else $error("write into a full queue");

    // Once running, the block stays running until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(running_reg) |-> running_reg)
        else $error("running flag dropped");

endmodule

// ===== design/message_ack_retry_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_ack_retry_controller_unit: queued message delivery with ack/retry
// Stream front end: input stage, control stage and output register.
// ----------------------------------------------------------------------------
// Each input item gives exactly one result item. The block takes one item
// per clock while the output is not stalled. An accepted item is held in the
// input stage register; the control stage then decodes it against the
// queue head, which the queue RAM returned from a read issued in the cycle
// before, and loads the output register. The input side stays ready while
// the output register is empty or being taken, so with m_tready high the
// rate is one item per cycle. The queue RAM is not cleared after reset;
// only entries already enqueued are ever read. Configuration writes are
// taken on any cycle at which cfg_we is high and are meant for idle times.
// ----------------------------------------------------------------------------
module message_ack_retry_controller_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [mack_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mack_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] peer_available, [16:1] message_id, [17] link_up, [23:18] zero
    input  logic [23:0]                       s_tdata,
    // [2:0] func
    input  logic [2:0]                        s_tuser,
    // Result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] send_heartbeat, [1] send_fault_notice, [2] send_message,
    // [18:3] out_message_id, [19] accepted, [20] peer_ready,
    // [23:21] queue_count, [24] running, [31:25] zero
    output logic [31:0]                       m_tdata,
    // [2:0] event_res
    output logic [2:0]                        m_tuser
);
    import mack_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    stage_fire;
    result_t stage_res;

    // Advance the control stage when the output register can take its result
    assign stage_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || stage_fire;

    // Input stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input stage payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.func           <= func_t'(s_tuser);
            in_item_reg.peer_available <= s_tdata[0];
            in_item_reg.message_id     <= s_tdata[16:1];
            in_item_reg.link_up        <= s_tdata[17];
        end
    end

    mack_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item_fire (stage_fire),
        .item      (in_item_reg),
        .result    (stage_res)
    );

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stage_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (stage_fire) begin
            out_res_reg <= stage_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.event_res;
    assign m_tdata  = {7'd0,
                       out_res_reg.running,
                       out_res_reg.queue_count,
                       out_res_reg.peer_ready,
                       out_res_reg.accepted,
                       out_res_reg.out_message_id,
                       out_res_reg.send_message,
                       out_res_reg.send_fault_notice,
                       out_res_reg.send_heartbeat};

endmodule
